>>> design/dkis_pkg.sv
// ----------------------------------------------------------------------------
// dkis_pkg
// shared constants and types for the descending key/tag sorter
// ----------------------------------------------------------------------------
package dkis_pkg;

    localparam int KEY_W         = 64;
    localparam int TAG_FIELD_W   = 16;
    localparam int DATA_W        = KEY_W + TAG_FIELD_W;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int TAG_BITS_DEF  = 16;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_TOP,
        ST_SCAN,
        ST_STORE,
        ST_EMIT
    } dkis_state_t;

endpackage

>>> design/dkis_pair_ram.sv
// ----------------------------------------------------------------------------
// dkis_pair_ram
// single write port, single registered read port storage for key/tag pairs
// ----------------------------------------------------------------------------
module dkis_pair_ram
    import dkis_pkg::*;
#(
    parameter int DEPTH = MAX_ITEMS_DEF,
    parameter int IDX_W = 6,
    parameter int WIDTH = DATA_W
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/descending_key_index_sorter_core.sv
// ----------------------------------------------------------------------------
// descending_key_index_sorter_core
// collects key/tag pairs, exchange-sorts them by descending key, streams them
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)          | tlast
//  s_      | in  | sort_key[63:0], tag[79:64]  | final_item
//  m_      | out | sorted_key[63:0],           | end_of_run
//          |     | sorted_tag[79:64]           |
//
//  loading takes one pair per cycle; the last pair starts the sort
//  sorting runs on the single compare/swap unit and one pair memory read port
//  results then leave at one per cycle while m_tready is high
//  s_tready is low from the last pair until the final result is taken
//  reset clears the sequencer and the item count; the pair memory needs none
// ----------------------------------------------------------------------------
module descending_key_index_sorter_core
    import dkis_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int TAG_BITS  = TAG_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // sort_key[63:0], tag[79:64]
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // sorted_key[63:0], sorted_tag[79:64]
    output logic              m_tlast
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int TAG_W = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
    localparam int ENT_W = KEY_W + TAG_W;

    dkis_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] a_reg, a_next;
    logic [IDX_W-1:0] b_reg, b_next;
    logic [ENT_W-1:0] cur_reg, cur_next;

    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [ENT_W-1:0] wr_data, rd_data;
    logic [IDX_W-1:0] last_idx;
    logic             swap;

    dkis_pair_ram #(
        .DEPTH (MAX_ITEMS),
        .IDX_W (IDX_W),
        .WIDTH (ENT_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    // cur holds the running winner for position a
    assign swap     = cur_reg[KEY_W-1:0] < rd_data[KEY_W-1:0];

    assign m_tdata  = {TAG_FIELD_W'(rd_data[ENT_W-1:KEY_W]), rd_data[KEY_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cur_next   = cur_reg;
        wr_en      = 1'b0;
        wr_addr    = a_reg;
        wr_data    = cur_reg;
        rd_en      = 1'b0;
        rd_addr    = a_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    // a full store drops the request but a last flag still counts
                    if (count_reg < CNT_W'(MAX_ITEMS)) begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        wr_data    = {s_tdata[KEY_W +: TAG_W], s_tdata[KEY_W-1:0]};
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        a_next     = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                rd_en = 1'b1;
                if (a_reg == last_idx) begin
                    rd_addr    = '0;
                    b_next     = '0;
                    state_next = ST_EMIT;
                end else begin
                    rd_addr    = a_reg;
                    state_next = ST_TOP;
                end
            end
            ST_TOP: begin
                cur_next   = rd_data;
                rd_en      = 1'b1;
                rd_addr    = a_reg + IDX_W'(1);
                b_next     = a_reg + IDX_W'(1);
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (swap) begin
                    wr_en    = 1'b1;
                    wr_addr  = b_reg;
                    wr_data  = cur_reg;
                    cur_next = rd_data;
                end
                if (b_reg == last_idx) begin
                    state_next = ST_STORE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = b_reg + IDX_W'(1);
                    b_next  = b_reg + IDX_W'(1);
                end
            end
            ST_STORE: begin
                wr_en      = 1'b1;
                wr_addr    = a_reg;
                wr_data    = cur_reg;
                a_next     = a_reg + IDX_W'(1);
                state_next = ST_FETCH;
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                m_tlast  = (b_reg == last_idx);
                if (m_tready) begin
                    if (b_reg == last_idx) begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = b_reg + IDX_W'(1);
                        b_next  = b_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output channels active together");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_scan_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (b_reg > a_reg) && (b_reg <= last_idx))
        else $error("scan index out of range");

    a_run_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && count_reg == '0))
        else $error("block not back to loading after last result");
`endif

endmodule

>>> bench/tb_descending_key_index_sorter_core.sv
// ----------------------------------------------------------------------------
// tb_descending_key_index_sorter_core
// self-checking bench for the descending key/tag sorter
// ----------------------------------------------------------------------------
// Sets of key/tag requests are streamed in. The last request of each set
// carries tlast. A local exchange-sort predictor keeps its own copy of the
// pair store and the count. On every closing request it queues the sorted
// pairs that the set should produce. Each result taken from the m_ side is
// checked field by field against the oldest queued pair.
// The run starts with a short directed table. Random sets follow: mostly
// small ones, plus full sets and overfull sets that push the store past
// capacity. Both sides idle at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module tb_descending_key_index_sorter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dkis_pkg::*;

    localparam int CAPACITY = MAX_ITEMS_DEF;
    localparam logic [TAG_FIELD_W-1:0] TAG_KEEP =
        (TAG_BITS_DEF >= TAG_FIELD_W) ? '1 : TAG_FIELD_W'((1 << TAG_BITS_DEF) - 1);
    localparam int RANDOM_ITEMS = 410;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_PRINTED = 20;

    typedef logic [KEY_W-1:0]       key_t;
    typedef logic [TAG_FIELD_W-1:0] tag_t;

    typedef struct {
        key_t key;
        tag_t tag;
        bit   last;
    } pair_t;

    typedef struct {
        key_t  key;
        tag_t  tag;
        bit    last;
        bit    typed;
        pair_t want;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // sort_key[63:0], tag[79:64]
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;   // sorted_key[63:0], sorted_tag[79:64]
    logic              m_tlast;

    descending_key_index_sorter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // predictor copy of the pair store
    key_t  held_keys [CAPACITY];
    tag_t  held_tags [CAPACITY];
    int    held_count;
    pair_t fresh_results[$];
    pair_t pending_sorted[$];

    int error_count;
    int requests_sent;
    int sets_sent;
    int overfull_sets;
    int results_seen;
    int send_quiet;
    int take_quiet;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // cycles to idle before the next request or result; quiet stretches give zero
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            quiet = $urandom_range(8, 40);
        end
        return $urandom_range(0, 7);
    endfunction

    // store one pair; on the closing request sort descending and list the pairs
    function automatic void absorb_pair(input key_t k, input tag_t t, input bit fin);
        key_t sk;
        tag_t st;
        fresh_results.delete();
        if (held_count < CAPACITY) begin
            held_keys[held_count] = k;
            held_tags[held_count] = t & TAG_KEEP;
            held_count++;
        end
        if (!fin) return;
        for (int a = 0; a < held_count; a++) begin
            for (int b = a + 1; b < held_count; b++) begin
                if (held_keys[a] < held_keys[b]) begin
                    sk = held_keys[a];
                    st = held_tags[a];
                    held_keys[a] = held_keys[b];
                    held_tags[a] = held_tags[b];
                    held_keys[b] = sk;
                    held_tags[b] = st;
                end
            end
        end
        for (int n = 0; n < held_count; n++) begin
            fresh_results.push_back('{held_keys[n], held_tags[n], n == held_count - 1});
        end
        held_count = 0;
    endfunction

    // entered at a falling edge, returns at the falling edge after acceptance
    task automatic send_pair(input key_t k, input tag_t t, input bit fin,
                             input bit typed, input pair_t want);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {t, k};
        s_tlast  = fin;
        do @(posedge aclk); while (!s_tready);
        absorb_pair(k, t, fin);
        if (typed) begin
            pending_sorted.push_back(want);
        end else begin
            foreach (fresh_results[i]) pending_sorted.push_back(fresh_results[i]);
        end
        requests_sent++;
        if (fin) sets_sent++;
        @(negedge aclk);
    endtask

    function automatic key_t draw_key();
        case ($urandom_range(0, 5))
            0: return key_t'($urandom_range(0, 7));   // heavy ties
            1: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return {1'b1, {(KEY_W-1){1'b0}}};
                endcase
            end
            2: return {1'b0, 11'($urandom), 20'($urandom), $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic stim_row_t row(input key_t k, input tag_t t, input bit fin);
        return '{k, t, fin, 1'b0, '{'0, '0, 1'b0}};
    endfunction

    function automatic stim_row_t single(input key_t k, input tag_t t);
        return '{k, t, 1'b1, 1'b1, '{k, t, 1'b1}};
    endfunction

    // result side: per result draw an idle count, then wait for the request
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = draw_gap(take_quiet);
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        pair_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_sorted.size() == 0) begin
                report_mismatch($sformatf("unexpected result key %h tag %h",
                    m_tdata[KEY_W-1:0], m_tdata[DATA_W-1:KEY_W]));
            end else begin
                want = pending_sorted.pop_front();
                if (m_tdata[KEY_W-1:0] !== want.key)
                    report_mismatch($sformatf("sorted_key %h, want %h",
                        m_tdata[KEY_W-1:0], want.key));
                if (m_tdata[DATA_W-1:KEY_W] !== want.tag)
                    report_mismatch($sformatf("sorted_tag %h, want %h",
                        m_tdata[DATA_W-1:KEY_W], want.tag));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("end_of_run %b, want %b",
                        m_tlast, want.last));
            end
        end
    end

    initial begin
        stim_row_t directed_rows[$];
        pair_t     none;
        int        set_size;
        int        pick;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        none     = '{'0, '0, 1'b0};
        held_count    = 0;
        error_count   = 0;
        requests_sent = 0;
        sets_sent     = 0;
        overfull_sets = 0;
        results_seen  = 0;
        send_quiet    = 0;
        take_quiet    = 0;

        // single-pair sets come straight back
        directed_rows.push_back(single('1, '1));
        directed_rows.push_back(single('0, '0));
        directed_rows.push_back(single({KEY_W/2{2'b10}}, {TAG_FIELD_W/2{2'b01}}));
        directed_rows.push_back(single({KEY_W/2{2'b01}}, {TAG_FIELD_W/2{2'b10}}));
        // ascending keys get fully reversed
        directed_rows.push_back(row(64'd1, 16'd10, 1'b0));
        directed_rows.push_back(row(64'd2, 16'd11, 1'b0));
        directed_rows.push_back(row(64'd3, 16'd12, 1'b0));
        directed_rows.push_back(row(64'd4, 16'd13, 1'b1));
        // equal keys, tie order set by the exchange procedure
        directed_rows.push_back(row(64'd5, 16'd1, 1'b0));
        directed_rows.push_back(row(64'd5, 16'd2, 1'b0));
        directed_rows.push_back(row(64'd7, 16'd3, 1'b0));
        directed_rows.push_back(row(64'd5, 16'd4, 1'b0));
        directed_rows.push_back(row(64'd5, 16'd5, 1'b1));
        // double bit patterns plus the top bit alone
        directed_rows.push_back(row(64'h3FF0_0000_0000_0000, 16'h0001, 1'b0));
        directed_rows.push_back(row(64'h8000_0000_0000_0000, 16'hAAAA, 1'b0));
        directed_rows.push_back(row(64'h7FFF_FFFF_FFFF_FFFF, 16'h5555, 1'b0));
        directed_rows.push_back(row(64'h0000_0000_0000_0001, 16'h8000, 1'b0));
        directed_rows.push_back(row(64'h4000_0000_0000_0000, 16'hFFFF, 1'b1));
        directed_rows.push_back(row('1, 16'h0000, 1'b0));
        directed_rows.push_back(row('0, 16'hFFFF, 1'b0));
        directed_rows.push_back(row('1, 16'h1234, 1'b1));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_pair(directed_rows[i].key, directed_rows[i].tag, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        // first random set overfills the store; the second is full or overfull
        for (int s = 0; requests_sent < RANDOM_ITEMS + directed_rows.size(); s++) begin
            pick = $urandom_range(0, 19);
            if (s == 0 || pick == 1) begin
                set_size = CAPACITY + $urandom_range(1, 3);
            end else if (s == 1 || pick == 0) begin
                set_size = CAPACITY;
            end else begin
                set_size = $urandom_range(1, 10);
            end
            if (set_size > CAPACITY) overfull_sets++;
            for (int k = 0; k < set_size; k++) begin
                send_pair(draw_key(), tag_t'($urandom), k == set_size - 1, 1'b0, none);
            end
        end
        s_tvalid = 1'b0;

        while (pending_sorted.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d requests in %0d sets (%0d past capacity), checked %0d results",
                 requests_sent, sets_sent, overfull_sets, results_seen);
        $display("mismatches: %0d", error_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
